/* sv/pss_pkg.sv */
// Shared types and constants for the pixel saturation scaler.
`timescale 1ns / 1ps
`default_nettype none

package pss_pkg;

   localparam int unsigned CHAN_W      = 8;
   localparam int unsigned GAIN_W      = 12;
   localparam int unsigned GAIN_FRAC_W = 8;
   localparam int unsigned NUM_W       = 2 * CHAN_W;
   localparam int unsigned GPROD_W     = GAIN_W + CHAN_W;

   localparam logic [GAIN_W-1:0] GAIN_ONE = 12'd256;

   // divider: two quotient bits per stage
   localparam int unsigned DIV_STAGES    = 4;
   localparam int unsigned DIV_STEP_BITS = CHAN_W / DIV_STAGES;

   // front, multiply, prepare, divider stages, output register
   localparam int unsigned LATENCY = 3 + DIV_STAGES + 1;

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
      logic [CHAN_W-1:0] alpha_in;
   } pixel_in_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic [CHAN_W-1:0] alpha_out;
   } pixel_out_type;

endpackage

`default_nettype wire

/* sv/pss_divider.sv */
// Pipelined restoring divider, 16-bit numerator below 256*den, 8-bit quotient.
`timescale 1ns / 1ps
`default_nettype none

module pss_divider (
   input  wire logic                        clock,
   input  wire logic [pss_pkg::NUM_W-1:0]   num,
   input  wire logic [pss_pkg::CHAN_W-1:0]  den,
   output logic      [pss_pkg::CHAN_W-1:0]  quo
);

   localparam int unsigned W      = pss_pkg::CHAN_W;
   localparam int unsigned Stages = pss_pkg::DIV_STAGES;
   localparam int unsigned Steps  = pss_pkg::DIV_STEP_BITS;

   logic [W-1:0] rem_src [Stages];
   logic [W-1:0] low_src [Stages];
   logic [W-1:0] quo_src [Stages];
   logic [W-1:0] den_src [Stages];

   logic [W-1:0] rem_in [Stages];
   logic [W-1:0] low_in [Stages];
   logic [W-1:0] quo_in [Stages];
   logic [W-1:0] rem_ff [Stages];
   logic [W-1:0] low_ff [Stages];
   logic [W-1:0] quo_ff [Stages];
   logic [W-1:0] den_ff [Stages];

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      if (s == 0) begin : g_first
         // upper numerator half is already below den, so it seeds the remainder
         assign rem_src[s] = num[pss_pkg::NUM_W-1:W];
         assign low_src[s] = num[W-1:0];
         assign quo_src[s] = '0;
         assign den_src[s] = den;
      end else begin : g_next
         assign rem_src[s] = rem_ff[s-1];
         assign low_src[s] = low_ff[s-1];
         assign quo_src[s] = quo_ff[s-1];
         assign den_src[s] = den_ff[s-1];
      end

      always_comb begin : step_logic
         logic [W-1:0] rem;
         logic [W-1:0] low;
         logic [W-1:0] q;
         logic [W:0]   trial;
         rem = rem_src[s];
         low = low_src[s];
         q   = quo_src[s];
         for (int i = 0; i < Steps; i++) begin
            trial = {rem, low[W-1]};
            low   = {low[W-2:0], 1'b0};
            if (trial >= {1'b0, den_src[s]}) begin
               trial = trial - {1'b0, den_src[s]};
               q     = {q[W-2:0], 1'b1};
            end else begin
               q     = {q[W-2:0], 1'b0};
            end
            rem = trial[W-1:0];
         end
         rem_in[s] = rem;
         low_in[s] = low;
         quo_in[s] = q;
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= rem_in[s];
         low_ff[s] <= low_in[s];
         quo_ff[s] <= quo_in[s];
         den_ff[s] <= den_src[s];
      end
   end

   assign quo = quo_ff[Stages-1];

endmodule

`default_nettype wire

/* sv/pixel_saturation_scaler.sv */
// Top level: RGBA8 pixel saturation scaler, fully pipelined.
`timescale 1ns / 1ps
`default_nettype none

// Scales the HSV saturation of each RGBA8 pixel by csr_wdata's gain (unsigned
// Q4.8, 256 = 1.0, reset 1.0), clamped so that saturation never exceeds 1.
// Hue and value (max channel) are kept, alpha passes through. Each channel
// becomes c' = v - ceil((v-c)*k), k = min(gain, v/delta), exact, no rounding
// of k. One transaction is taken every clock: busy is always low. The result
// appears on rsp_pixel with rsp_strobe high for one cycle; the receiver cannot
// stall. The pipeline has 8 stages: max/min, multipliers, compare and
// numerator prep, four stages of a two-bit-per-stage divider for the v/delta
// clamp path, and the output register. Write the gain register only while no
// transaction is in flight.

module pixel_saturation_scaler (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          start,
   output logic                               busy,
   input  wire pss_pkg::pixel_in_type         req_pixel,
   // response channel
   output logic                               rsp_strobe,
   output pss_pkg::pixel_out_type             rsp_pixel,
   // gain register
   input  wire logic                          csr_we,
   input  wire logic [pss_pkg::GAIN_W-1:0]    csr_wdata
);

   localparam int unsigned CW  = pss_pkg::CHAN_W;
   localparam int unsigned GW  = pss_pkg::GAIN_W;
   localparam int unsigned PW  = pss_pkg::GPROD_W;
   localparam int unsigned NW  = pss_pkg::NUM_W;
   localparam int unsigned FW  = pss_pkg::GAIN_FRAC_W;
   localparam int unsigned DS  = pss_pkg::DIV_STAGES;
   localparam int unsigned NCH = 3;

   // data that rides alongside the divider
   typedef struct packed {
      logic [CW-1:0]          v;
      logic [CW-1:0]          alpha;
      logic                   clamp;
      logic [NCH-1:0][GW-1:0] sub_g;
   } side_type;

   // receiver has no back-pressure, so input is always open
   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // gain register
   logic [GW-1:0] gain_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= pss_pkg::GAIN_ONE;
      end else if (csr_we) begin
         gain_ff <= csr_wdata;
      end
   end

   // stage 1: max, min, per-channel distance to max
   logic [NCH-1:0][CW-1:0] chan;
   logic [CW-1:0]          v_in;
   logic [CW-1:0]          mn_in;
   logic [NCH-1:0][CW-1:0] d_in;

   assign chan[0] = req_pixel.red_in;
   assign chan[1] = req_pixel.green_in;
   assign chan[2] = req_pixel.blue_in;

   always_comb begin
      v_in  = chan[0];
      mn_in = chan[0];
      for (int i = 1; i < NCH; i++) begin
         if (chan[i] > v_in) begin
            v_in = chan[i];
         end
         if (chan[i] < mn_in) begin
            mn_in = chan[i];
         end
      end
      for (int i = 0; i < NCH; i++) begin
         d_in[i] = v_in - chan[i];
      end
   end

   logic                   s1_vld_ff;
   logic [CW-1:0]          s1_v_ff;
   logic [CW-1:0]          s1_delta_ff;
   logic [CW-1:0]          s1_alpha_ff;
   logic [NCH-1:0][CW-1:0] s1_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_v_ff     <= v_in;
      s1_delta_ff <= v_in - mn_in;
      s1_alpha_ff <= req_pixel.alpha_in;
      s1_d_ff     <= d_in;
   end

   // stage 2: products
   logic                   s2_vld_ff;
   logic [CW-1:0]          s2_v_ff;
   logic [CW-1:0]          s2_delta_ff;
   logic [CW-1:0]          s2_alpha_ff;
   logic [PW-1:0]          s2_gd_ff;
   logic [NCH-1:0][PW-1:0] s2_dg_ff;
   logic [NCH-1:0][NW-1:0] s2_dv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_v_ff     <= s1_v_ff;
      s2_delta_ff <= s1_delta_ff;
      s2_alpha_ff <= s1_alpha_ff;
      s2_gd_ff    <= PW'(gain_ff) * PW'(s1_delta_ff);
      for (int i = 0; i < NCH; i++) begin
         s2_dg_ff[i] <= PW'(s1_d_ff[i]) * PW'(gain_ff);
         s2_dv_ff[i] <= NW'(s1_d_ff[i]) * NW'(s1_v_ff);
      end
   end

   // stage 3: clamp decision, gain-path subtrahend (rounded up),
   // divider numerator with ceiling bias. A grey pixel never clamps.
   logic                   s3_vld_ff;
   logic [CW-1:0]          s3_delta_ff;
   side_type               s3_side_ff;
   logic [NCH-1:0][NW-1:0] s3_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic [PW-1:0] biased;
      s3_delta_ff       <= s2_delta_ff;
      s3_side_ff.v      <= s2_v_ff;
      s3_side_ff.alpha  <= s2_alpha_ff;
      s3_side_ff.clamp  <= s2_gd_ff > {{(PW-CW-FW){1'b0}}, s2_v_ff, {FW{1'b0}}};
      for (int i = 0; i < NCH; i++) begin
         biased              = s2_dg_ff[i] + PW'(pss_pkg::GAIN_ONE - 1'b1);
         s3_side_ff.sub_g[i] <= biased[PW-1:FW];
         s3_num_ff[i]        <= s2_dv_ff[i] + NW'(s2_delta_ff) - NW'(1);
      end
   end

   // stages 4..7: dividers for the clamp path, quotient = ceil(d*v/delta)
   logic [NCH-1:0][CW-1:0] quo;

   for (genvar c = 0; c < NCH; c++) begin : g_div
      pss_divider u_div (
         .clock (clock),
         .num   (s3_num_ff[c]),
         .den   (s3_delta_ff),
         .quo   (quo[c])
      );
   end

   logic     dly_vld_ff  [DS];
   side_type dly_side_ff [DS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DS; k++) begin
            dly_vld_ff[k] <= 1'b0;
         end
      end else begin
         dly_vld_ff[0] <= s3_vld_ff;
         for (int k = 1; k < DS; k++) begin
            dly_vld_ff[k] <= dly_vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      dly_side_ff[0] <= s3_side_ff;
      for (int k = 1; k < DS; k++) begin
         dly_side_ff[k] <= dly_side_ff[k-1];
      end
   end

   // stage 8: pick subtrahend, subtract from value
   side_type               fin;
   logic [NCH-1:0][CW-1:0] res_in;

   assign fin = dly_side_ff[DS-1];

   always_comb begin
      logic [GW-1:0] sub;
      for (int i = 0; i < NCH; i++) begin
         sub = fin.clamp ? GW'(quo[i]) : fin.sub_g[i];
         if (sub > GW'(fin.v)) begin
            sub = GW'(fin.v);
         end
         res_in[i] = fin.v - sub[CW-1:0];
      end
   end

   logic                   out_vld_ff;
   pss_pkg::pixel_out_type out_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= dly_vld_ff[DS-1];
      end
   end

   always_ff @(posedge clock) begin
      out_pix_ff.red_out   <= res_in[0];
      out_pix_ff.green_out <= res_in[1];
      out_pix_ff.blue_out  <= res_in[2];
      out_pix_ff.alpha_out <= fin.alpha;
   end

   assign rsp_strobe = out_vld_ff;
   assign rsp_pixel  = out_pix_ff;

endmodule

`default_nettype wire

/* sv/pss_checker.sv */
// Port-level checker for the pixel saturation scaler, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module pss_checker (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    start,
   input wire logic                    busy,
   input wire pss_pkg::pixel_in_type   req_pixel,
   input wire logic                    rsp_strobe,
   input wire pss_pkg::pixel_out_type  rsp_pixel
);

   localparam int unsigned Lat = pss_pkg::LATENCY;

   logic [pss_pkg::CHAN_W-1:0] in_max;
   logic [pss_pkg::CHAN_W-1:0] out_max;

   always_comb begin
      in_max = req_pixel.red_in;
      if (req_pixel.green_in > in_max) in_max = req_pixel.green_in;
      if (req_pixel.blue_in > in_max) in_max = req_pixel.blue_in;
      out_max = rsp_pixel.red_out;
      if (rsp_pixel.green_out > out_max) out_max = rsp_pixel.green_out;
      if (rsp_pixel.blue_out > out_max) out_max = rsp_pixel.blue_out;
   end

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##Lat rsp_strobe)
      else $error("accepted transaction produced no response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, Lat))
      else $error("response without a transaction");

   a_alpha_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_pixel.alpha_out == $past(req_pixel.alpha_in, Lat))
      else $error("alpha changed");

   a_value_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> out_max == $past(in_max, Lat))
      else $error("value channel changed");

endmodule

bind pixel_saturation_scaler pss_checker u_pss_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_pixel  (req_pixel),
   .rsp_strobe (rsp_strobe),
   .rsp_pixel  (rsp_pixel)
);

`default_nettype wire
